@@ rtl/occupancy_light_controller_defines.svh @@
// assertion macros shared by the occupancy light controller rtl
`ifndef OCCUPANCY_LIGHT_CONTROLLER_DEFINES_SVH
`define OCCUPANCY_LIGHT_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk and disabled in reset
`define OLC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk and disabled in reset
`define OLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/olc_pkg.sv @@
// types and constants of the occupancy light controller
package olc_pkg;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_SENSOR = 2'd1;
  localparam logic [1:0] KIND_CMD    = 2'd2;

  localparam logic [7:0] CMD_SET     = 8'd20;
  localparam logic [7:0] CMD_SET_ACK = 8'd22;
  localparam logic [7:0] CMD_STATUS  = 8'd50;

  localparam logic [7:0] MODE_OFF  = 8'd0;
  localparam logic [7:0] MODE_ON   = 8'd1;
  localparam logic [7:0] MODE_AUTO = 8'd2;

  localparam logic [1:0] RPT_PERIODIC = 2'd0;
  localparam logic [1:0] RPT_EVENT    = 2'd1;
  localparam logic [1:0] RPT_ACK      = 2'd2;
  localparam logic [1:0] RPT_STATUS   = 2'd3;

  localparam int          ABS_W       = 14;
  localparam logic [13:0] SEC_PER_MIN = 14'd60;
  localparam logic [7:0]  HOLD_RESET  = 8'd20;

  localparam int          APB_AW        = 3;
  localparam logic [0:0]  REG_INIT_HOLD = 1'b0;

  typedef struct packed {
    logic [1:0] kind;
    logic       sensor_level;
    logic [7:0] command_code;
    logic [7:0] command_mode;
    logic [7:0] command_hold_minutes;
  } olc_item_t;

  typedef struct packed {
    logic       relay_on;
    logic       occupied;
    logic       report_valid;
    logic [1:0] report_code;
    logic       report_sensor;
    logic [7:0] hold_minutes_now;
    logic [7:0] mode_now;
    logic       save_hold;
  } olc_result_t;

endpackage

@@ rtl/olc_if.sv @@
// input and result channel interfaces of the occupancy light controller
interface olc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       sensor_level;
  logic [7:0] command_code;
  logic [7:0] command_mode;
  logic [7:0] command_hold_minutes;

  modport source (output valid, kind, sensor_level, command_code, command_mode,
                  command_hold_minutes, input ready);
  modport sink (input valid, kind, sensor_level, command_code, command_mode,
                command_hold_minutes, output ready);
endinterface

interface olc_out_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic       occupied;
  logic       report_valid;
  logic [1:0] report_code;
  logic       report_sensor;
  logic [7:0] hold_minutes_now;
  logic [7:0] mode_now;
  logic       save_hold;

  modport source (output valid, relay_on, occupied, report_valid, report_code,
                  report_sensor, hold_minutes_now, mode_now, save_hold, input ready);
  modport sink (input valid, relay_on, occupied, report_valid, report_code,
                report_sensor, hold_minutes_now, mode_now, save_hold, output ready);
endinterface

@@ rtl/olc_core.sv @@
// occupancy state registers and the per-item update logic
`include "occupancy_light_controller_defines.svh"

module olc_core #(
  parameter int TPS = 100,
  parameter int RPS = 600,
  localparam int PW = $clog2(TPS + 1),
  localparam int RW = $clog2(RPS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_acc,
  input  olc_pkg::olc_item_t  item,
  input  logic                cfg_wr,
  input  logic [7:0]          cfg_hold,
  output olc_pkg::olc_result_t res
);

  logic                     sensor_r, sensor_nxt;
  logic                     present_r, present_nxt;
  logic                     running_r, running_nxt;
  logic [olc_pkg::ABS_W-1:0] abs_r, abs_nxt;
  logic [PW-1:0]            pre_r, pre_nxt;
  logic [RW-1:0]            rep_r, rep_nxt;
  logic [7:0]               strip_r, strip_nxt;
  logic [7:0]               hold_r, hold_nxt;
  logic                     relay_r, relay_nxt;

  logic                     send;
  logic [1:0]               rcode;
  logic                     save;
  logic [PW-1:0]            pre_inc;
  logic [RW-1:0]            rep_inc;
  logic [olc_pkg::ABS_W-1:0] abs_inc;
  logic [olc_pkg::ABS_W-1:0] hold_lim;
  logic                     is_set;

  assign pre_inc  = pre_r + PW'(1);
  assign rep_inc  = rep_r + RW'(1);
  assign abs_inc  = abs_r + olc_pkg::ABS_W'(1);
  assign hold_lim = {6'd0, hold_r} * olc_pkg::SEC_PER_MIN;
  assign is_set   = (item.command_code == olc_pkg::CMD_SET) ||
                    (item.command_code == olc_pkg::CMD_SET_ACK);

  always_comb begin
    sensor_nxt  = sensor_r;
    present_nxt = present_r;
    running_nxt = running_r;
    abs_nxt     = abs_r;
    pre_nxt     = pre_r;
    rep_nxt     = rep_r;
    strip_nxt   = strip_r;
    hold_nxt    = hold_r;
    relay_nxt   = relay_r;
    send        = 1'b0;
    rcode       = olc_pkg::RPT_PERIODIC;
    save        = 1'b0;

    case (item.kind)
      olc_pkg::KIND_TICK: begin
        if (pre_inc >= PW'(TPS)) begin
          pre_nxt = '0;
          if (rep_inc >= RW'(RPS)) begin
            rep_nxt = '0;
            send    = 1'b1;
            rcode   = olc_pkg::RPT_PERIODIC;
          end else begin
            rep_nxt = rep_inc;
          end
          if (running_r) begin
            // event report overrides a periodic one on the same second
            if (abs_inc >= hold_lim) begin
              running_nxt = 1'b0;
              abs_nxt     = '0;
              present_nxt = 1'b0;
              send        = 1'b1;
              rcode       = olc_pkg::RPT_EVENT;
            end else begin
              abs_nxt = abs_inc;
            end
          end
        end else begin
          pre_nxt = pre_inc;
        end
      end
      olc_pkg::KIND_SENSOR: begin
        if (item.sensor_level != sensor_r) begin
          abs_nxt    = '0;
          sensor_nxt = item.sensor_level;
          if (item.sensor_level) begin
            running_nxt = 1'b0;
            if (!present_r) begin
              present_nxt = 1'b1;
              send        = 1'b1;
              rcode       = olc_pkg::RPT_EVENT;
            end
          end else begin
            running_nxt = 1'b1;
          end
        end
      end
      olc_pkg::KIND_CMD: begin
        if (is_set) begin
          if (item.command_code == olc_pkg::CMD_SET_ACK) begin
            send  = 1'b1;
            rcode = olc_pkg::RPT_ACK;
          end
          strip_nxt = item.command_mode;
          if (item.command_mode == olc_pkg::MODE_ON) begin
            relay_nxt = 1'b1;
          end else if (item.command_mode == olc_pkg::MODE_OFF) begin
            relay_nxt = 1'b0;
          end
          if (hold_r != item.command_hold_minutes) begin
            hold_nxt = item.command_hold_minutes;
            save     = 1'b1;
          end
        end else if (item.command_code == olc_pkg::CMD_STATUS) begin
          send  = 1'b1;
          rcode = olc_pkg::RPT_STATUS;
        end
      end
      default: begin
      end
    endcase

    if (strip_nxt == olc_pkg::MODE_AUTO) begin
      relay_nxt = present_nxt;
    end
    // any report restarts the periodic count
    if (send) begin
      rep_nxt = '0;
    end
  end

  always_comb begin
    res.relay_on         = relay_nxt;
    res.occupied         = present_nxt;
    res.report_valid     = send;
    res.report_code      = rcode;
    res.report_sensor    = sensor_nxt;
    res.hold_minutes_now = hold_nxt;
    res.mode_now         = strip_nxt;
    res.save_hold        = save;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r  <= 1'b0;
      present_r <= 1'b0;
      running_r <= 1'b0;
      abs_r     <= '0;
      pre_r     <= '0;
      rep_r     <= '0;
      strip_r   <= olc_pkg::MODE_OFF;
      hold_r    <= olc_pkg::HOLD_RESET;
      relay_r   <= 1'b0;
    end else if (cfg_wr) begin
      hold_r <= cfg_hold;
    end else if (item_acc) begin
      sensor_r  <= sensor_nxt;
      present_r <= present_nxt;
      running_r <= running_nxt;
      abs_r     <= abs_nxt;
      pre_r     <= pre_nxt;
      rep_r     <= rep_nxt;
      strip_r   <= strip_nxt;
      hold_r    <= hold_nxt;
      relay_r   <= relay_nxt;
    end
  end

  `OLC_ASSERT_NOW(a_pre_range, 1'b1, pre_r < PW'(TPS), "tick prescaler out of range")
  `OLC_ASSERT_NOW(a_rep_range, 1'b1, rep_r < RW'(RPS), "report counter out of range")
  `OLC_ASSERT_NOW(a_absence_ctx, running_r || sensor_r, present_r && !(running_r && sensor_r),
                  "absence count or motion seen without occupancy")

endmodule

@@ rtl/olc_outbuf.sv @@
// two-entry result buffer between the update logic and the result channel
`include "occupancy_light_controller_defines.svh"

module olc_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  olc_pkg::olc_result_t push_data,
  output logic                 full,
  input  logic                 pop_ready,
  output logic                 head_valid,
  output olc_pkg::olc_result_t head_data
);

  olc_pkg::olc_result_t main_r, skid_r;
  logic                 main_v_r, skid_v_r;
  logic                 pop;

  assign pop        = main_v_r && pop_ready;
  assign full       = skid_v_r;
  assign head_valid = main_v_r;
  assign head_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (push) begin
        if (!main_v_r || pop) begin
          main_v_r <= 1'b1;
        end else begin
          skid_v_r <= 1'b1;
        end
      end else if (pop) begin
        main_v_r <= skid_v_r;
        skid_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_v_r || pop) begin
        main_r <= push_data;
      end else begin
        skid_r <= push_data;
      end
    end else if (pop) begin
      main_r <= skid_r;
    end
  end

  `OLC_ASSERT_NOW(a_skid_needs_main, skid_v_r, main_v_r, "skid entry held with empty head")
  `OLC_ASSERT_NEXT(a_no_overrun, skid_v_r && !pop, skid_v_r && main_v_r,
                   "buffered item lost while stalled")

endmodule

@@ rtl/occupancy_light_controller.sv @@
// Occupancy light controller: each item (10 ms tick, motion sample or host command) is
// processed by the state update logic and its result item is registered in a result
// buffer that presents it on out_item. A new item can be taken every cycle; the two-entry
// buffer keeps in_item.ready high while one result waits, so the input stalls only when
// two results are pending. The state register update sets this rate.
// The one configuration register (initial hold minutes, any address with paddr[2] low)
// also reloads the active hold time when written. No clearing pass runs after reset.
module occupancy_light_controller #(
  parameter int TICKS_PER_SECOND      = 100,
  parameter int REPORT_PERIOD_SECONDS = 600
) (
  input  logic                       clk,
  input  logic                       rst_n,
  olc_in_if.sink                     in_item,
  olc_out_if.source                  out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [olc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  olc_pkg::olc_item_t   item;
  olc_pkg::olc_result_t res;
  olc_pkg::olc_result_t head;
  logic                 buf_full;
  logic                 item_acc;
  logic                 cfg_wr;
  logic [7:0]           init_hold_r;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[2] == olc_pkg::REG_INIT_HOLD);
  assign prdata   = (paddr[2] == olc_pkg::REG_INIT_HOLD) ? {24'd0, init_hold_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_hold_r <= olc_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      init_hold_r <= pwdata[7:0];
    end
  end

  assign in_item.ready = !buf_full;
  assign item_acc      = in_item.valid && !buf_full;

  assign item.kind                 = in_item.kind;
  assign item.sensor_level         = in_item.sensor_level;
  assign item.command_code         = in_item.command_code;
  assign item.command_mode         = in_item.command_mode;
  assign item.command_hold_minutes = in_item.command_hold_minutes;

  olc_core #(
    .TPS (TICKS_PER_SECOND),
    .RPS (REPORT_PERIOD_SECONDS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_acc (item_acc),
    .item     (item),
    .cfg_wr   (cfg_wr),
    .cfg_hold (pwdata[7:0]),
    .res      (res)
  );

  olc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (item_acc),
    .push_data  (res),
    .full       (buf_full),
    .pop_ready  (out_item.ready),
    .head_valid (out_item.valid),
    .head_data  (head)
  );

  assign out_item.relay_on         = head.relay_on;
  assign out_item.occupied         = head.occupied;
  assign out_item.report_valid     = head.report_valid;
  assign out_item.report_code      = head.report_code;
  assign out_item.report_sensor    = head.report_sensor;
  assign out_item.hold_minutes_now = head.hold_minutes_now;
  assign out_item.mode_now         = head.mode_now;
  assign out_item.save_hold        = head.save_hold;

endmodule
